// ===== rtl/cau_pkg.sv =====
`default_nettype none
package cau_pkg;

	// fixed point format
	localparam int FRAC_BITS = 8;

	// divider sizing: quotient bits kept, remainder and divisor widths
	localparam int QW = 17;
	localparam int DW = 32;
	localparam int RW = DW + 1;
	localparam int LW = QW - 1;
	localparam int NW = DW + FRAC_BITS;
	localparam int CW = DW + QW + FRAC_BITS;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_CONJ = 3'd4,
		OP_MAG  = 3'd5
	} op_t;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_DBZ = 2'd2;

	// one divider lane: partial remainder, dividend bits still to enter, quotient so far
	typedef struct packed {
		logic [RW-1:0] rem;
		logic [LW-1:0] low;
		logic [QW-1:0] quo;
	} lane_t;

	// request context travelling beside the divider lanes
	typedef struct packed {
		logic          valid;
		logic          is_div;
		logic [15:0]   re;
		logic [15:0]   im;
		logic [1:0]    status;
		logic          neg_re;
		logic          neg_im;
		logic          ovf_re;
		logic          ovf_im;
		logic [DW-1:0] den;
	} info_t;

	typedef struct packed {
		logic [15:0] val;
		logic        sat;
	} sat_t;

	// clamp a wide signed value to 16 bits
	function automatic sat_t sat16(input logic signed [33:0] x);
		sat_t r;
		if (x > 34'sd32767) begin
			r.val = 16'h7fff;
			r.sat = 1'b1;
		end else if (x < -34'sd32768) begin
			r.val = 16'h8000;
			r.sat = 1'b1;
		end else begin
			r.val = x[15:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/cau_if.sv =====
`default_nettype none
interface cau_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [15:0] a_real;
	logic [15:0] a_imag;
	logic [15:0] b_real;
	logic [15:0] b_imag;

	modport source(output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
	modport sink(input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_real;
	logic [15:0] result_imag;
	logic [1:0]  status;

	modport source(output valid, result_real, result_imag, status, input ready);
	modport sink(input valid, result_real, result_imag, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/complex_arithmetic_unit_core.sv =====
// Complex arithmetic unit on signed Q8.8 operands.
// Requests arrive on the operand channel (operation, a_real, a_imag,
// b_real, b_imag) and each gives exactly one request on the result
// channel (result_real, result_imag, status), in order.
// Operations: add, subtract, multiply, divide, conjugate of a, squared
// magnitude of a; codes 6 and 7 return zero with status ok.
// From acceptance to the result being shown a request passes through:
// one multiply stage, one sum stage, a chain of 17 divider cells (one
// quotient bit each, both parts at once) and the output register.
// Every operation runs through the full chain so order is kept.
// The chain length sets the latency. Throughput is one request per
// cycle unless the receiver stalls with a result waiting; then the
// whole pipeline holds and operand.ready drops until the result is taken.
// Reset clears all valid flags; no result is pending afterwards.
// Status: 0 ok, 1 saturated, 2 divide by zero (result then zero).
`default_nettype none
module complex_arithmetic_unit_core (
	input  wire logic clk,
	input  wire logic arst_n,
	cau_in_if.sink    operand,
	cau_out_if.source result
);

	logic en;
	cau_pkg::info_t info_c [0:cau_pkg::QW];
	cau_pkg::lane_t re_c   [0:cau_pkg::QW];
	cau_pkg::lane_t im_c   [0:cau_pkg::QW];

	// whole pipeline advances unless a result waits unaccepted
	assign en = !result.valid || result.ready;

	cau_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.operand (operand),
		.info    (info_c[0]),
		.lane_re (re_c[0]),
		.lane_im (im_c[0])
	);

	for (genvar g = 0; g < cau_pkg::QW; g++) begin : g_cell
		cau_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.info_i (info_c[g]),
			.re_i   (re_c[g]),
			.im_i   (im_c[g]),
			.info_o (info_c[g+1]),
			.re_o   (re_c[g+1]),
			.im_o   (im_c[g+1])
		);
	end

	// sign and clamp a quotient
	function automatic cau_pkg::sat_t fin(input logic [cau_pkg::QW-1:0] q,
	                                      input logic neg, input logic ovf);
		cau_pkg::sat_t r;
		logic [cau_pkg::QW-1:0] nq;
		nq = -q;
		if (neg) begin
			r.sat = ovf || (q > cau_pkg::QW'(32768));
			r.val = r.sat ? 16'h8000 : nq[15:0];
		end else begin
			r.sat = ovf || (q > cau_pkg::QW'(32767));
			r.val = r.sat ? 16'h7fff : q[15:0];
		end
		return r;
	endfunction

	cau_pkg::info_t last;
	cau_pkg::sat_t  dr, di;
	logic [15:0]    fre, fim;
	logic [1:0]     fst;

	always_comb begin
		last = info_c[cau_pkg::QW];
		dr = fin(re_c[cau_pkg::QW].quo, last.neg_re, last.ovf_re);
		di = fin(im_c[cau_pkg::QW].quo, last.neg_im, last.ovf_im);
		if (last.is_div) begin
			fre = dr.val;
			fim = di.val;
			fst = (dr.sat || di.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end else begin
			fre = last.re;
			fim = last.im;
			fst = last.status;
		end
	end

	// output register
	logic        valid_q;
	logic [15:0] re_q, im_q;
	logic [1:0]  st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_q <= fre;
			im_q <= fim;
			st_q <= fst;
		end
	end

	assign result.valid       = valid_q;
	assign result.result_real = re_q;
	assign result.result_imag = im_q;
	assign result.status      = st_q;

	// checks
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		operand.ready == (!result.valid || result.ready))
		else $error("operand ready does not follow output stall");

	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == cau_pkg::ST_DBZ) |->
		(result.result_real == 16'h0000 && result.result_imag == 16'h0000))
		else $error("divide by zero with non-zero result");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.status != 2'd3))
		else $error("reserved status code");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !result.ready) |=> (valid_q && $stable(re_q) && $stable(st_q)))
		else $error("stalled result changed");

endmodule
`default_nettype wire

// ===== rtl/cau_front.sv =====
`default_nettype none
module cau_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	cau_in_if.sink               operand,
	output cau_pkg::info_t       info,
	output cau_pkg::lane_t       lane_re,
	output cau_pkg::lane_t       lane_im
);

	logic signed [15:0] ar, ai, br, bi, x0, x1;
	logic               is_mag;

	logic               valid_s1;
	logic [2:0]         op_s1;
	logic signed [15:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [31:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;

	assign ar = operand.a_real;
	assign ai = operand.a_imag;
	assign br = operand.b_real;
	assign bi = operand.b_imag;
	assign operand.ready = en;

	// squared magnitude reuses the first two multipliers
	assign is_mag = (operand.operation == cau_pkg::OP_MAG);
	assign x0 = is_mag ? ar : br;
	assign x1 = is_mag ? ai : bi;

	// stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= operand.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= operand.operation;
			ar_s1 <= ar;
			ai_s1 <= ai;
			br_s1 <= br;
			bi_s1 <= bi;
			p0_s1 <= ar * x0;
			p1_s1 <= ai * x1;
			p2_s1 <= ar * bi;
			p3_s1 <= ai * br;
			p4_s1 <= br * br;
			p5_s1 <= bi * bi;
		end
	end

	function automatic logic [cau_pkg::DW-1:0] DW_CAST(input logic [32:0] v);
		return v[cau_pkg::DW-1:0];
	endfunction

	// stage 2: sums, direct results and divider set-up
	cau_pkg::info_t     nx;
	cau_pkg::lane_t     nre, nim;
	cau_pkg::sat_t      sr, si;
	logic signed [32:0] sum_a, sum_b, dif_a, dif_b;
	logic signed [32:0] num_re, num_im;
	logic [cau_pkg::DW-1:0] mag_re, mag_im, den;
	logic [cau_pkg::NW-1:0] n_re, n_im;
	logic signed [16:0] ar17, ai17, br17, bi17;

	always_comb begin
		ar17 = 17'(ar_s1);
		ai17 = 17'(ai_s1);
		br17 = 17'(br_s1);
		bi17 = 17'(bi_s1);
		sum_a = 33'(p0_s1) + 33'(p1_s1);
		dif_a = 33'(p0_s1) - 33'(p1_s1);
		sum_b = 33'(p2_s1) + 33'(p3_s1);
		dif_b = 33'(p3_s1) - 33'(p2_s1);
		num_re = sum_a;
		num_im = dif_b;
		den = DW_CAST(33'(p4_s1) + 33'(p5_s1));
		mag_re = num_re[32] ? DW_CAST(-num_re) : DW_CAST(num_re);
		mag_im = num_im[32] ? DW_CAST(-num_im) : DW_CAST(num_im);
		n_re = {mag_re, {cau_pkg::FRAC_BITS{1'b0}}};
		n_im = {mag_im, {cau_pkg::FRAC_BITS{1'b0}}};

		sr = '0;
		si = '0;
		nx = '0;
		nx.valid = valid_s1;
		nx.status = cau_pkg::ST_OK;
		nx.den = den;
		nx.neg_re = num_re[32];
		nx.neg_im = num_im[32];
		nx.ovf_re = cau_pkg::CW'(n_re) >= cau_pkg::CW'({den, {cau_pkg::QW{1'b0}}});
		nx.ovf_im = cau_pkg::CW'(n_im) >= cau_pkg::CW'({den, {cau_pkg::QW{1'b0}}});

		unique case (op_s1)
			cau_pkg::OP_ADD: begin
				sr = cau_pkg::sat16(34'(ar17 + br17));
				si = cau_pkg::sat16(34'(ai17 + bi17));
			end
			cau_pkg::OP_SUB: begin
				sr = cau_pkg::sat16(34'(ar17 - br17));
				si = cau_pkg::sat16(34'(ai17 - bi17));
			end
			cau_pkg::OP_MUL: begin
				sr = cau_pkg::sat16(34'(dif_a >>> cau_pkg::FRAC_BITS));
				si = cau_pkg::sat16(34'(sum_b >>> cau_pkg::FRAC_BITS));
			end
			cau_pkg::OP_DIV: begin
				nx.is_div = (den != '0);
			end
			cau_pkg::OP_CONJ: begin
				sr = cau_pkg::sat16(34'(ar17));
				si = cau_pkg::sat16(34'(-ai17));
			end
			cau_pkg::OP_MAG: begin
				sr = cau_pkg::sat16(34'(sum_a >>> cau_pkg::FRAC_BITS));
			end
			default: begin
			end
		endcase

		nx.re = sr.val;
		nx.im = si.val;
		if (op_s1 == cau_pkg::OP_DIV && den == '0)
			nx.status = cau_pkg::ST_DBZ;
		else if (sr.sat || si.sat)
			nx.status = cau_pkg::ST_SAT;

		// first partial remainder holds the dividend's top bits
		nre.rem = cau_pkg::RW'(n_re >> cau_pkg::LW);
		nre.low = n_re[cau_pkg::LW-1:0];
		nre.quo = '0;
		nim.rem = cau_pkg::RW'(n_im >> cau_pkg::LW);
		nim.low = n_im[cau_pkg::LW-1:0];
		nim.quo = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info <= '0;
		end else if (en) begin
			info <= nx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_re <= nre;
			lane_im <= nim;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cau_cell.sv =====
`default_nettype none
module cau_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  cau_pkg::info_t  info_i,
	input  cau_pkg::lane_t  re_i,
	input  cau_pkg::lane_t  im_i,
	output cau_pkg::info_t  info_o,
	output cau_pkg::lane_t  re_o,
	output cau_pkg::lane_t  im_o
);

	// one restoring step: compare, subtract, shift in the next dividend bit
	function automatic cau_pkg::lane_t step(input cau_pkg::lane_t l,
	                                        input logic [cau_pkg::DW-1:0] d);
		cau_pkg::lane_t r;
		logic [cau_pkg::RW-1:0] t;
		logic                   ge;
		ge = l.rem >= {1'b0, d};
		t = ge ? (l.rem - {1'b0, d}) : l.rem;
		r.rem = {t[cau_pkg::DW-1:0], l.low[cau_pkg::LW-1]};
		r.low = {l.low[cau_pkg::LW-2:0], 1'b0};
		r.quo = {l.quo[cau_pkg::QW-2:0], ge};
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_o <= '0;
		end else if (en) begin
			info_o <= info_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_o <= step(re_i, info_i.den);
			im_o <= step(im_i, info_i.den);
		end
	end

endmodule
`default_nettype wire

// ===== test/cau_checker.sv =====
`default_nettype none
module cau_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_ready,
	input  wire logic [2:0] in_operation,
	input  wire logic [15:0] in_a_real,
	input  wire logic [15:0] in_a_imag,
	input  wire logic [15:0] in_b_real,
	input  wire logic [15:0] in_b_imag,
	input  wire logic out_valid,
	input  wire logic out_ready,
	input  wire logic [15:0] out_result_real,
	input  wire logic [15:0] out_result_imag,
	input  wire logic [1:0] out_status,
	output int errors,
	output int pending
);

	typedef struct packed {
		logic [15:0] re;
		logic [15:0] im;
		logic [1:0]  st;
	} answer_t;

	answer_t answers[$];

	// clamp to signed 16 bits, noting any clamp
	function automatic logic [15:0] clamp16(input longint x, inout bit hit);
		if (x > 32767) begin
			hit = 1;
			return 16'h7fff;
		end
		if (x < -32768) begin
			hit = 1;
			return 16'h8000;
		end
		return x[15:0];
	endfunction

	// quotient of (num << FRAC_BITS) by den, truncated toward zero
	function automatic longint scaled_quotient(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag <<< cau_pkg::FRAC_BITS) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic answer_t complex_result(input logic [2:0] op,
			input logic signed [15:0] ar, input logic signed [15:0] ai,
			input logic signed [15:0] br, input logic signed [15:0] bi);
		longint re;
		longint im;
		longint den;
		bit hit;
		logic [1:0] st;
		answer_t r;
		re = 0;
		im = 0;
		hit = 0;
		st = cau_pkg::ST_OK;
		case (op)
			cau_pkg::OP_ADD: begin
				re = longint'(ar) + br;
				im = longint'(ai) + bi;
			end
			cau_pkg::OP_SUB: begin
				re = longint'(ar) - br;
				im = longint'(ai) - bi;
			end
			cau_pkg::OP_MUL: begin
				re = (longint'(ar) * br - longint'(ai) * bi) >>> cau_pkg::FRAC_BITS;
				im = (longint'(ar) * bi + longint'(ai) * br) >>> cau_pkg::FRAC_BITS;
			end
			cau_pkg::OP_DIV: begin
				den = longint'(br) * br + longint'(bi) * bi;
				if (den == 0) st = cau_pkg::ST_DBZ;
				else begin
					re = scaled_quotient(longint'(ar) * br + longint'(ai) * bi, den);
					im = scaled_quotient(longint'(ai) * br - longint'(ar) * bi, den);
				end
			end
			cau_pkg::OP_CONJ: begin
				re = ar;
				im = -longint'(ai);
			end
			cau_pkg::OP_MAG:
				re = (longint'(ar) * ar + longint'(ai) * ai) >>> cau_pkg::FRAC_BITS;
			default: ;
		endcase
		r.re = clamp16(re, hit);
		r.im = clamp16(im, hit);
		r.st = (st == cau_pkg::ST_OK && hit) ? cau_pkg::ST_SAT : st;
		return r;
	endfunction

	// predict on each accepted request, compare each result request
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				answers.push_back(complex_result(in_operation, in_a_real, in_a_imag,
					in_b_real, in_b_imag));
			if (out_valid && out_ready) begin
				if (answers.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10) $display("unexpected result %h %h %0d",
						out_result_real, out_result_imag, out_status);
				end else begin
					want = answers.pop_front();
					if (want.re !== out_result_real || want.im !== out_result_imag
							|| want.st !== out_status) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("mismatch: expected %h %h %0d, got %h %h %0d",
								want.re, want.im, want.st, out_result_real,
								out_result_imag, out_status);
					end
				end
			end
			pending <= answers.size();
		end
	end
endmodule
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;

	logic clk;
	logic arst_n;
	int errors;
	int pending;
	int phase;
	int idle_cycles;
	bit hold_off;
	bit done;

	cau_in_if  operand();
	cau_out_if result();

	complex_arithmetic_unit_core dut (
		.clk(clk), .arst_n(arst_n), .operand(operand.sink), .result(result.source)
	);

	cau_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(operand.valid), .in_ready(operand.ready),
		.in_operation(operand.operation), .in_a_real(operand.a_real),
		.in_a_imag(operand.a_imag), .in_b_real(operand.b_real),
		.in_b_imag(operand.b_imag),
		.out_valid(result.valid), .out_ready(result.ready),
		.out_result_real(result.result_real), .out_result_imag(result.result_imag),
		.out_status(result.status),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// sender idles in phases 1 and 3, receiver in phases 2 and 3
	function automatic bit sender_idle();
		return (phase == 1 || phase == 3) && $urandom_range(99) < ((phase == 1) ? 72 : 35);
	endfunction

	// receiver side: random stalls plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) result.ready <= 1'b0;
		else if (hold_off) result.ready <= 1'b0;
		else if ((phase == 2 || phase == 3) && $urandom_range(99) < ((phase == 2) ? 72 : 35))
			result.ready <= 1'b0;
		else result.ready <= 1'b1;
	end

	initial begin
		hold_off = 0;
		wait (phase == 4);
		hold_off = 1;
		repeat (300) @(posedge clk);
		hold_off = 0;
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (operand.valid && operand.ready) || (result.valid && result.ready)
				|| done)
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 5000) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	function automatic logic [15:0] pick_value();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(1024)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send(input logic [2:0] op, input logic [15:0] ar,
			input logic [15:0] ai, input logic [15:0] br, input logic [15:0] bi);
		while (sender_idle()) begin
			operand.valid <= 1'b0;
			@(posedge clk);
		end
		operand.valid     <= 1'b1;
		operand.operation <= op;
		operand.a_real    <= ar;
		operand.a_imag    <= ai;
		operand.b_real    <= br;
		operand.b_imag    <= bi;
		@(posedge clk);
		while (!operand.ready) @(posedge clk);
	endtask

	initial begin
		logic [15:0] v[4];
		logic [2:0] op;
		done = 0;
		phase = 0;
		arst_n = 0;
		operand.valid = 0;
		operand.operation = '0;
		operand.a_real = '0;
		operand.a_imag = '0;
		operand.b_real = '0;
		operand.b_imag = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every operation, zero divisor, conjugate of most negative
		send(cau_pkg::OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		send(cau_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
		send(cau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send(cau_pkg::OP_MUL, 16'h0100, 16'hff00, 16'h0080, 16'hffff);
		send(cau_pkg::OP_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
		send(cau_pkg::OP_DIV, 16'h0300, 16'h0100, 16'h0200, 16'h0000);
		send(cau_pkg::OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
		send(cau_pkg::OP_DIV, 16'hff00, 16'h0001, 16'h0000, 16'h8000);
		send(cau_pkg::OP_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send(cau_pkg::OP_CONJ, 16'h1234, 16'h8000, 16'hffff, 16'hffff);
		send(cau_pkg::OP_CONJ, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
		send(cau_pkg::OP_MAG, 16'h8000, 16'h8000, 16'h1234, 16'h4321);
		send(cau_pkg::OP_MAG, 16'h0100, 16'hff00, 16'h0000, 16'h0000);
		send(3'd6, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send(cau_pkg::OP_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

		// random requests across the idling phases, then the long hold-off
		for (int p = 0; p < 5; p++) begin
			phase = p;
			for (int i = 0; i < 240; i++) begin
				foreach (v[k]) v[k] = pick_value();
				op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
					: 3'($urandom_range(5));
				send(op, v[0], v[1], v[2], v[3]);
			end
		end
		operand.valid <= 1'b0;
		phase = 0;

		while (pending != 0) @(posedge clk);
		done = 1;
		repeat (40) @(posedge clk);
		if (errors == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
